@@ hw/rtl/sacl_pkg.sv @@
// Shared constants and types for the set-associative cache LRU tracker.
// Used by the lookup, statistics and top-level modules.
`default_nettype none

package sacl_pkg;

    localparam int ADDR_BITS   = 48;
    localparam int TOT_W       = 32;
    localparam int WAY_OUT_W   = 4;
    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = 4;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 200;

    localparam logic [CFG_IDX_W-1:0]  CFG_OFFSET_WIDTH = 4'd0;
    localparam logic [CFG_IDX_W-1:0]  CFG_INDEX_WIDTH  = 4'd1;
    localparam logic [CFG_DATA_W-1:0] OFFSET_RESET     = 4'd6;
    localparam logic [CFG_DATA_W-1:0] INDEX_RESET      = 4'd8;

    typedef logic [TOT_W-1:0] total_t;

    typedef struct packed {
        logic                 hit;
        logic                 evicted;
        logic                 wrote_back;
        logic [WAY_OUT_W-1:0] way;
    } outcome_t;

    typedef struct packed {
        total_t writebacks;
        total_t evictions;
        total_t misses;
        total_t hits;
        total_t writes;
        total_t reads;
    } totals_t;

endpackage

`default_nettype wire

@@ hw/rtl/sacl_tag_ram.sv @@
// Synchronous set memory holding one row of way entries per set.
// Clears every row after reset, one row per cycle. Uses no package items.
`default_nettype none

module sacl_tag_ram #(
    parameter  int DEPTH = 1024,
    parameter  int ROW_W = 100,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [ROW_W-1:0] rd_data,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [ROW_W-1:0] wr_data,
    output logic                  busy
);

    logic [ROW_W-1:0] mem [DEPTH];
    logic [ROW_W-1:0] rd_data_reg;
    logic [AW-1:0]    clr_ptr_reg;
    logic             clr_busy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_ptr_reg  <= '0;
        end else if (clr_busy_reg) begin
            clr_ptr_reg <= clr_ptr_reg + 1'b1;
            if (clr_ptr_reg == AW'(DEPTH - 1)) begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (clr_busy_reg) begin
            mem[clr_ptr_reg] <= '0;
        end else if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = clr_busy_reg;

endmodule

`default_nettype wire

@@ hw/rtl/sacl_lookup.sv @@
// Tag compare, victim choice and LRU rank update for one set row.
// Depends on sacl_pkg for the address width and the outcome type.
`default_nettype none

module sacl_lookup #(
    parameter  int WAYS   = 2,
    localparam int RANK_W = (WAYS > 1) ? $clog2(WAYS) : 1,
    localparam int EW     = sacl_pkg::ADDR_BITS + RANK_W + 2,
    localparam int ROW_W  = WAYS * EW
) (
    input  wire logic [ROW_W-1:0]              row_in,
    input  wire logic [sacl_pkg::ADDR_BITS-1:0] tag_in,
    input  wire logic                          is_write,
    output logic      [ROW_W-1:0]              row_out,
    output sacl_pkg::outcome_t                 outcome
);

    import sacl_pkg::*;

    logic                 e_valid [WAYS];
    logic                 e_dirty [WAYS];
    logic [RANK_W-1:0]    e_rank  [WAYS];
    logic [ADDR_BITS-1:0] e_tag   [WAYS];

    logic              hit;
    logic              found;
    logic [RANK_W-1:0] hit_way;
    logic [RANK_W-1:0] inv_way;
    logic [RANK_W-1:0] lru_way;
    logic [RANK_W-1:0] way;
    logic [RANK_W:0]   old_rank;

    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            e_valid[w] = row_in[w*EW];
            e_dirty[w] = row_in[w*EW + 1];
            e_rank[w]  = row_in[w*EW + 2 +: RANK_W];
            e_tag[w]   = row_in[w*EW + 2 + RANK_W +: ADDR_BITS];
        end
    end

    always_comb begin
        hit     = 1'b0;
        found   = 1'b0;
        hit_way = '0;
        inv_way = '0;
        lru_way = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (e_valid[w] && (e_tag[w] == tag_in)) begin
                hit     = 1'b1;
                hit_way = RANK_W'(w);
            end
            if (!e_valid[w]) begin
                found   = 1'b1;
                inv_way = RANK_W'(w);
            end
            if (e_rank[w] == RANK_W'(WAYS - 1)) begin
                lru_way = RANK_W'(w);
            end
        end
        way = hit ? hit_way : (found ? inv_way : lru_way);
        old_rank = (hit || !found) ? {1'b0, e_rank[way]} : (RANK_W + 1)'(WAYS);
    end

    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            row_out[w*EW]                          = e_valid[w];
            row_out[w*EW + 1]                      = e_dirty[w];
            row_out[w*EW + 2 +: RANK_W]            = e_rank[w];
            row_out[w*EW + 2 + RANK_W +: ADDR_BITS] = e_tag[w];
            if (RANK_W'(w) == way) begin
                row_out[w*EW + 2 +: RANK_W] = '0;
                if (hit) begin
                    row_out[w*EW + 1] = e_dirty[w] | is_write;
                end else begin
                    row_out[w*EW]                           = 1'b1;
                    row_out[w*EW + 1]                       = is_write;
                    row_out[w*EW + 2 + RANK_W +: ADDR_BITS] = tag_in;
                end
            end else if (e_valid[w] && ({1'b0, e_rank[w]} < old_rank)) begin
                row_out[w*EW + 2 +: RANK_W] = e_rank[w] + 1'b1;
            end
        end
    end

    always_comb begin
        outcome.hit        = hit;
        outcome.evicted    = !hit && !found;
        outcome.wrote_back = !hit && !found && e_dirty[way];
        outcome.way        = WAY_OUT_W'(way);
    end

endmodule

`default_nettype wire

@@ hw/rtl/sacl_stats.sv @@
// Six saturating access counters, bumped once per completed request.
// Depends on sacl_pkg for the outcome and totals types.
`default_nettype none

module sacl_stats (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               update,
    input  wire logic               is_write,
    input  wire sacl_pkg::outcome_t outcome,
    output sacl_pkg::totals_t       totals
);

    import sacl_pkg::*;

    total_t reads_reg;
    total_t writes_reg;
    total_t hits_reg;
    total_t misses_reg;
    total_t evictions_reg;
    total_t writebacks_reg;

    function automatic total_t bump(input total_t c);
        return (c == '1) ? c : c + 1'b1;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reads_reg      <= '0;
            writes_reg     <= '0;
            hits_reg       <= '0;
            misses_reg     <= '0;
            evictions_reg  <= '0;
            writebacks_reg <= '0;
        end else if (update) begin
            if (is_write) begin
                writes_reg <= bump(writes_reg);
            end else begin
                reads_reg <= bump(reads_reg);
            end
            if (outcome.hit) begin
                hits_reg <= bump(hits_reg);
            end else begin
                misses_reg <= bump(misses_reg);
            end
            if (outcome.evicted) begin
                evictions_reg <= bump(evictions_reg);
            end
            if (outcome.wrote_back) begin
                writebacks_reg <= bump(writebacks_reg);
            end
        end
    end

    always_comb begin
        totals.reads      = reads_reg;
        totals.writes     = writes_reg;
        totals.hits       = hits_reg;
        totals.misses     = misses_reg;
        totals.evictions  = evictions_reg;
        totals.writebacks = writebacks_reg;
    end

endmodule

`default_nettype wire

@@ hw/rtl/set_assoc_cache_lru_tracker.sv @@
// Set-associative write-back cache tracker with true LRU, tags only.
// A request reads the set row from the tag RAM, then updates it and writes it back.
// The single RAM port pair allows one read and one write per request.
// Result is registered in the output register when the update completes; it holds until taken.
// After reset, a clear pass over all 2^floor(log2(MAX_SETS)) set rows runs before the first request.
// Depends on sacl_pkg, sacl_tag_ram, sacl_lookup and sacl_stats.
`default_nettype none

module set_assoc_cache_lru_tracker #(
    parameter int MAX_SETS = 1024,
    parameter int WAYS     = 2
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [sacl_pkg::IN_TDATA_W-1:0] s_tdata,  // address[47:0]
    input  wire logic [0:0]                      s_tuser,  // is_write[0]
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // hit[0], evicted[1], wrote_back[2], way_used[6:3], read_total[38:7],
    // write_total[70:39], hit_total[102:71], miss_total[134:103],
    // eviction_total[166:135], writeback_total[198:167], zero[199]
    output logic [sacl_pkg::OUT_TDATA_W-1:0]     m_tdata,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [sacl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [sacl_pkg::CFG_DATA_W-1:0] cfg_data
);

    import sacl_pkg::*;

    localparam int IDX_LIM = $clog2(MAX_SETS + 1) - 1;
    localparam int DEPTH   = 1 << IDX_LIM;
    localparam int SET_W   = (IDX_LIM > 0) ? IDX_LIM : 1;
    localparam int RANK_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int ROW_W   = WAYS * (ADDR_BITS + RANK_W + 2);

    typedef enum logic [1:0] {
        ST_IDLE   = 2'b01,
        ST_UPDATE = 2'b10
    } state_t;

    state_t state_reg, state_next;

    logic [CFG_DATA_W-1:0] offset_reg;
    logic [CFG_DATA_W-1:0] index_reg;
    logic [ADDR_BITS-1:0]  tag_reg;
    logic [SET_W-1:0]      set_reg;
    logic                  wr_reg;
    outcome_t              outcome_reg;
    logic                  m_valid_reg, m_valid_next;

    logic                  s_acc;
    logic                  advance;
    logic                  clr_busy;
    logic [4:0]            iw_eff;
    logic [ADDR_BITS-1:0]  shifted;
    logic [SET_W-1:0]      set_now;
    logic [ADDR_BITS-1:0]  tag_now;
    logic [ROW_W-1:0]      row_rd;
    logic [ROW_W-1:0]      row_wr;
    outcome_t              outcome;
    totals_t               totals;

    // Address split
    always_comb begin
        iw_eff  = ({1'b0, index_reg} > 5'(IDX_LIM)) ? 5'(IDX_LIM) : {1'b0, index_reg};
        shifted = s_tdata >> offset_reg;
        for (int i = 0; i < SET_W; i++) begin
            set_now[i] = shifted[i] && (5'(i) < iw_eff);
        end
        tag_now = s_tdata >> (6'(offset_reg) + 6'(iw_eff));
    end

    assign s_tready  = (state_reg == ST_IDLE) && !clr_busy;
    assign s_acc     = s_tvalid && s_tready;
    assign advance   = (state_reg == ST_UPDATE) && (!m_valid_reg || m_tready);
    assign cfg_ready = 1'b1;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc) state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                if (advance) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (advance) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            offset_reg  <= OFFSET_RESET;
            index_reg   <= INDEX_RESET;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    CFG_OFFSET_WIDTH: offset_reg <= cfg_data;
                    CFG_INDEX_WIDTH:  index_reg  <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            tag_reg <= tag_now;
            set_reg <= set_now;
            wr_reg  <= s_tuser[0];
        end
        if (advance) begin
            outcome_reg <= outcome;
        end
    end

    sacl_tag_ram #(
        .DEPTH (DEPTH),
        .ROW_W (ROW_W)
    ) u_tag_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (s_acc),
        .rd_addr (set_now),
        .rd_data (row_rd),
        .wr_en   (advance),
        .wr_addr (set_reg),
        .wr_data (row_wr),
        .busy    (clr_busy)
    );

    sacl_lookup #(
        .WAYS (WAYS)
    ) u_lookup (
        .row_in   (row_rd),
        .tag_in   (tag_reg),
        .is_write (wr_reg),
        .row_out  (row_wr),
        .outcome  (outcome)
    );

    sacl_stats u_stats (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .update   (advance),
        .is_write (wr_reg),
        .outcome  (outcome),
        .totals   (totals)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, totals.writebacks, totals.evictions, totals.misses,
                       totals.hits, totals.writes, totals.reads, outcome_reg.way,
                       outcome_reg.wrote_back, outcome_reg.evicted, outcome_reg.hit};

    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_busy |-> !s_acc)
        else $error("request accepted during clear pass");

    a_hit_no_evict: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && outcome.hit |-> !outcome.evicted && !outcome.wrote_back)
        else $error("hit reported an eviction");

    a_wb_needs_evict: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && outcome.wrote_back |-> outcome.evicted)
        else $error("writeback without eviction");

    a_advance_result: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid_reg && (state_reg == ST_IDLE))
        else $error("completed request did not produce a result");

endmodule

`default_nettype wire
